[src/berdec_pkg.sv]
// Shared types and constants for the BER element decoder.
// Depends on nothing; every other file imports it.
package berdec_pkg;

  localparam logic [2:0] KIND_INT  = 3'd0;
  localparam logic [2:0] KIND_ARC  = 3'd1;
  localparam logic [2:0] KIND_BYTE = 3'd2;
  localparam logic [2:0] KIND_NULL = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TAG       = 3'd1;
  localparam logic [2:0] ERR_UNSUPP    = 3'd2;
  localparam logic [2:0] ERR_LEN_LONG  = 3'd3;
  localparam logic [2:0] ERR_OVER_CAP  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  localparam logic [7:0] TAG_INTEGER = 8'h02;
  localparam logic [7:0] TAG_BITSTR  = 8'h03;
  localparam logic [7:0] TAG_OCTETS  = 8'h04;
  localparam logic [7:0] TAG_NULL    = 8'h05;
  localparam logic [7:0] TAG_OID     = 8'h06;
  localparam logic [7:0] TAG_IPADDR  = 8'h40;
  localparam logic [7:0] TAG_OPAQUE  = 8'h44;
  localparam logic [7:0] TAG_NSAP    = 8'h45;

  localparam logic [6:0]  MAX_LEN_BYTES = 7'd4;
  localparam logic [31:0] ARC_DIVISOR   = 32'd40;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] expected_tag;
    logic [7:0] capacity;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  error_code;
    logic [7:0]  element_tag;
    logic        last;
  } out_item_t;

  // One queue entry carries the results of one input byte: one result, or
  // the two arcs of a split first subidentifier.
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  err;
    logic [7:0]  tag;
    logic        last;
    logic        pair;
    logic [31:0] val_a;
    logic [31:0] val_b;
  } q_entry_t;

endpackage

[src/berdec_front.sv]
// Front part: accepts bytes, runs the tag/length/content parse and pushes results.
// Depends on berdec_pkg.
module berdec_front import berdec_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  input  logic      q_full,
  output logic      push,
  output q_entry_t  push_entry
);

  localparam int ACC_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam logic [ACC_W-1:0] VMASK = {ACC_W{1'b1}} >> (ACC_W - VALUE_BITS);

  typedef enum logic [4:0] {
    PH_TAG  = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_LONG = 5'b00100,
    PH_BODY = 5'b01000,
    PH_NULL = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       tag_r, tag_nxt;
  logic [2:0]       lbl_r, lbl_nxt;
  logic [31:0]      content_r, content_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [8:0]       arcs_r, arcs_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       cap_r, cap_nxt;

  logic             accept;
  logic             done;
  logic             has_res;
  q_entry_t         ent;
  logic             lk;
  logic [31:0]      lk_len;
  logic             arc_go;
  logic [31:0]      arc_v;
  logic             arc_last;
  logic [9:0]       arc_sum;
  logic [1:0]       arc_cnt;
  logic [ACC_W-1:0] acc_int;
  logic [ACC_W-1:0] acc_oid;
  logic [ACC_W-1:0] int_base;
  logic [7:0]       b;

  assign accept = in_valid && !q_full;
  assign b      = in_item.data_byte;

  always_comb begin
    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    lbl_nxt     = lbl_r;
    content_nxt = content_r;
    acc_nxt     = acc_r;
    arcs_nxt    = arcs_r;
    first_nxt   = first_r;
    cap_nxt     = cap_r;
    done        = 1'b0;
    has_res     = 1'b0;
    ent         = '0;
    lk          = 1'b0;
    lk_len      = '0;
    arc_go      = 1'b0;
    arc_v       = '0;
    arc_last    = 1'b0;
    arc_cnt     = 2'd1;
    arc_sum     = '0;

    int_base = first_r ? (b[7] ? VMASK : '0) : acc_r;
    acc_int  = ((int_base << 8) | ACC_W'(b)) & VMASK;
    acc_oid  = ACC_W'({acc_r[24:0], b[6:0]});

    case (phase_r)
      PH_LEN: begin
        if (b[7]) begin
          content_nxt = '0;
          if (b[6:0] > MAX_LEN_BYTES) begin
            done = 1'b1;
            has_res = 1'b1;
            ent.kind = KIND_ERR;
            ent.err = ERR_LEN_LONG;
          end else if (b[6:0] == 7'd0) begin
            lk = 1'b1;
          end else begin
            lbl_nxt = b[2:0];
            phase_nxt = PH_LONG;
          end
        end else begin
          content_nxt = 32'(b);
          lk = 1'b1;
          lk_len = 32'(b);
        end
      end
      PH_LONG: begin
        content_nxt = {content_r[23:0], b};
        lbl_nxt = lbl_r - 3'd1;
        if (lbl_nxt == 3'd0) begin
          lk = 1'b1;
          lk_len = content_nxt;
        end
      end
      PH_BODY: begin
        content_nxt = content_r - 32'd1;
        if (tag_r == TAG_INTEGER) begin
          acc_nxt = acc_int;
          first_nxt = 1'b0;
          if (content_nxt == 32'd0) begin
            done = 1'b1;
            has_res = 1'b1;
            ent.kind = KIND_INT;
            ent.val_a = acc_int[31:0];
            ent.last = 1'b1;
          end
        end else if (tag_r == TAG_OID) begin
          if (!b[7] || content_nxt == 32'd0) begin
            acc_nxt = '0;
            arc_go = 1'b1;
            arc_v = acc_oid[31:0];
            arc_last = (content_nxt == 32'd0);
          end else begin
            acc_nxt = acc_oid;
          end
        end else begin
          done = (content_nxt == 32'd0);
          has_res = 1'b1;
          ent.kind = KIND_BYTE;
          ent.val_a = 32'(b);
          ent.last = (content_nxt == 32'd0);
        end
      end
      PH_NULL: begin
        done = 1'b1;
        has_res = 1'b1;
        ent.kind = KIND_NULL;
        ent.last = 1'b1;
      end
      default: begin
        // Expecting a tag byte; unused phase codes land here as well.
        phase_nxt   = PH_TAG;
        tag_nxt     = b;
        cap_nxt     = in_item.capacity;
        lbl_nxt     = '0;
        content_nxt = '0;
        acc_nxt     = '0;
        arcs_nxt    = '0;
        first_nxt   = 1'b1;
        if (b != in_item.expected_tag) begin
          done = 1'b1;
          has_res = 1'b1;
          ent.kind = KIND_ERR;
          ent.err = ERR_TAG;
        end else if (b == TAG_NULL) begin
          phase_nxt = PH_NULL;
        end else if (b == TAG_INTEGER || b == TAG_OID || b == TAG_BITSTR ||
                     b == TAG_OCTETS || b == TAG_IPADDR || b == TAG_OPAQUE ||
                     b == TAG_NSAP) begin
          phase_nxt = PH_LEN;
        end else begin
          done = 1'b1;
          has_res = 1'b1;
          ent.kind = KIND_ERR;
          ent.err = ERR_UNSUPP;
        end
      end
    endcase

    // The length is now known: check it and decide how the content starts.
    if (lk) begin
      acc_nxt = '0;
      first_nxt = 1'b1;
      if (tag_r == TAG_OID) begin
        if (lk_len == 32'd0) begin
          arc_go = 1'b1;
          arc_v = '0;
          arc_last = 1'b1;
        end else begin
          phase_nxt = PH_BODY;
        end
      end else if (lk_len > 32'(cap_r)) begin
        done = 1'b1;
        has_res = 1'b1;
        ent.kind = KIND_ERR;
        ent.err = ERR_OVER_CAP;
      end else if (lk_len == 32'd0) begin
        done = 1'b1;
        if (tag_r == TAG_INTEGER) begin
          has_res = 1'b1;
          ent.kind = KIND_INT;
          ent.last = 1'b1;
        end
      end else begin
        phase_nxt = PH_BODY;
      end
    end

    // An arc is ready; the first subidentifier counts as two arcs.
    if (arc_go) begin
      arc_cnt = first_nxt ? 2'd2 : 2'd1;
      arc_sum = 10'(arcs_r) + 10'(arc_cnt);
      if (arc_sum > 10'(cap_r)) begin
        done = 1'b1;
        has_res = 1'b1;
        ent.kind = KIND_ERR;
        ent.err = ERR_OVER_CAP;
        ent.last = 1'b1;
      end else begin
        has_res = 1'b1;
        ent.kind = KIND_ARC;
        ent.last = arc_last;
        if (first_nxt) begin
          ent.pair = 1'b1;
          if (arc_v < ARC_DIVISOR) begin
            ent.val_a = 32'd0;
            ent.val_b = arc_v;
          end else if (arc_v < (ARC_DIVISOR << 1)) begin
            ent.val_a = 32'd1;
            ent.val_b = arc_v - ARC_DIVISOR;
          end else begin
            ent.val_a = 32'd2;
            ent.val_b = arc_v - (ARC_DIVISOR << 1);
          end
        end else begin
          ent.val_a = arc_v;
        end
        arcs_nxt = arc_sum[8:0];
        first_nxt = 1'b0;
        done = arc_last;
      end
    end

    if (!done && in_item.final_byte) begin
      done = 1'b1;
      has_res = 1'b1;
      ent = '0;
      ent.kind = KIND_ERR;
      ent.err = ERR_TRUNCATED;
    end

    if (ent.kind == KIND_ERR) begin
      ent.last = 1'b1;
    end
    ent.tag = tag_nxt;

    if (done) begin
      phase_nxt = PH_TAG;
    end
  end

  assign push       = accept && has_res;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      tag_r     <= '0;
      lbl_r     <= '0;
      content_r <= '0;
      acc_r     <= '0;
      arcs_r    <= '0;
      first_r   <= 1'b1;
      cap_r     <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      tag_r     <= tag_nxt;
      lbl_r     <= lbl_nxt;
      content_r <= content_nxt;
      acc_r     <= acc_nxt;
      arcs_r    <= arcs_nxt;
      first_r   <= first_nxt;
      cap_r     <= cap_nxt;
    end
  end

endmodule

[src/berdec_fifo.sv]
// Short queue of result entries between the front and back parts.
// Depends on berdec_pkg.
module berdec_fifo import berdec_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output logic     not_empty,
  output logic     full
);

  q_entry_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[src/berdec_back.sv]
// Back part: takes queue entries apart into single results in an output register.
// Depends on berdec_pkg.
module berdec_back import berdec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  logic      not_empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      half_r, half_nxt;
  logic      load;

  assign load = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    half_nxt      = half_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = not_empty;
      if (not_empty) begin
        out_nxt.kind        = head.kind;
        out_nxt.error_code  = head.err;
        out_nxt.element_tag = head.tag;
        if (head.pair && !half_r) begin
          // First arc of a split pair; the entry stays for the second.
          out_nxt.value = head.val_a;
          out_nxt.last  = 1'b0;
          half_nxt      = 1'b1;
        end else begin
          out_nxt.value = half_r ? head.val_b : head.val_a;
          out_nxt.last  = head.last;
          half_nxt      = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[src/ber_element_decoder_core.sv]
// Channel   Direction  Payload      Handshake
// in_       input      in_item_t    in_valid / in_stall
// out_      output     out_item_t   out_valid / out_stall
//
// One byte is accepted per cycle while the four-entry result queue has room.
// An item's results enter the queue at the edge that accepts it, then the output
// register; the split first arc of an object identifier gives two output results, all else one.
// Reset (synchronous, rst_n low) returns the parser to expecting a tag byte
// and empties the queue. A stall on the output fills the queue, and in_stall
// rises only when it is full.
module ber_element_decoder_core import berdec_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_push_entry;
  logic     q_pop;
  q_entry_t q_head;
  logic     q_not_empty;

  assign in_stall = q_full;

  berdec_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  berdec_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  berdec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("result pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("result popped from an empty queue");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == KIND_ERR) |-> out_item.last)
    else $error("error result not marked last");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.error_code != ERR_NONE) |-> out_item.kind == KIND_ERR)
    else $error("error code on a non-error result");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

[tb/ber_element_decoder_checker.sv]
`timescale 1ns / 1ps
// Result checker for the BER element decoder: follows both channels, predicts
// the results of every accepted byte and compares them in order.
// Depends on berdec_pkg for the item types, tags, kinds and error codes.
module ber_element_decoder_checker import berdec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatches,
  output int        pending,
  output int        checked
);

  typedef enum logic [4:0] {
    P_TAG  = 5'b00001,
    P_LEN  = 5'b00010,
    P_LONG = 5'b00100,
    P_BODY = 5'b01000,
    P_NULL = 5'b10000
  } parse_phase_t;

  parse_phase_t phase;
  logic [7:0]   tag_q;
  logic [7:0]   cap_q;
  logic [2:0]   len_left;
  logic [31:0]  content_left;
  logic [31:0]  acc;
  logic [8:0]   arcs_done;
  logic         first_pending;
  logic         elem_done;
  out_item_t    step_out[$];
  out_item_t    results_due[$];
  out_item_t    due_item;
  int           bad_n;
  int           seen_n;

  function automatic bit carries_bytes(logic [7:0] t);
    return t == TAG_BITSTR || t == TAG_OCTETS || t == TAG_IPADDR ||
           t == TAG_OPAQUE || t == TAG_NSAP;
  endfunction

  function automatic void put_res(logic [2:0] k, logic [31:0] v, logic [2:0] e, logic l);
    out_item_t r;
    r.kind        = k;
    r.value       = v;
    r.error_code  = e;
    r.element_tag = tag_q;
    r.last        = l;
    step_out.push_back(r);
  endfunction

  // An error replaces anything the byte would otherwise have produced.
  function automatic void raise_err(logic [2:0] code);
    step_out.delete();
    put_res(KIND_ERR, 32'd0, code, 1'b1);
    elem_done = 1'b1;
  endfunction

  function automatic void emit_arc(logic [31:0] v, logic closes);
    logic [31:0] hi;
    int          need;
    need = first_pending ? 2 : 1;
    if (int'(arcs_done) + need > int'(cap_q)) begin
      raise_err(ERR_OVER_CAP);
    end else begin
      if (first_pending) begin
        hi = (v < ARC_DIVISOR) ? 32'd0 : ((v < 2 * ARC_DIVISOR) ? 32'd1 : 32'd2);
        put_res(KIND_ARC, hi, ERR_NONE, 1'b0);
        put_res(KIND_ARC, v - hi * ARC_DIVISOR, ERR_NONE, closes);
      end else begin
        put_res(KIND_ARC, v, ERR_NONE, closes);
      end
      arcs_done     = arcs_done + 9'(need);
      first_pending = 1'b0;
      if (closes) elem_done = 1'b1;
    end
  endfunction

  function automatic void length_known();
    acc           = '0;
    first_pending = 1'b1;
    if (tag_q == TAG_OID) begin
      if (content_left == 0) emit_arc(32'd0, 1'b1);
      else phase = P_BODY;
    end else if (content_left > {24'd0, cap_q}) begin
      raise_err(ERR_OVER_CAP);
    end else if (content_left == 0) begin
      elem_done = 1'b1;
      if (tag_q == TAG_INTEGER) put_res(KIND_INT, 32'd0, ERR_NONE, 1'b1);
    end else begin
      phase = P_BODY;
    end
  endfunction

  function automatic void body_byte(logic [7:0] b);
    logic closes;
    content_left = content_left - 32'd1;
    closes       = (content_left == 0);
    if (tag_q == TAG_INTEGER) begin
      // The first content byte decides the sign extension.
      if (first_pending) begin
        acc           = {32{b[7]}};
        first_pending = 1'b0;
      end
      acc = {acc[23:0], b};
      if (closes) begin
        elem_done = 1'b1;
        put_res(KIND_INT, acc, ERR_NONE, 1'b1);
      end
    end else if (tag_q == TAG_OID) begin
      acc = {acc[24:0], b[6:0]};
      if (!b[7] || closes) begin
        emit_arc(acc, closes);
        acc = '0;
      end
    end else begin
      if (closes) elem_done = 1'b1;
      put_res(KIND_BYTE, {24'd0, b}, ERR_NONE, closes);
    end
  endfunction

  function automatic void decode_byte(in_item_t it);
    logic [7:0] b;
    logic [6:0] k;
    b = it.data_byte;
    step_out.delete();
    elem_done = 1'b0;
    case (phase)
      P_TAG: begin
        tag_q         = b;
        cap_q         = it.capacity;
        len_left      = '0;
        content_left  = '0;
        acc           = '0;
        arcs_done     = '0;
        first_pending = 1'b1;
        if (b != it.expected_tag) raise_err(ERR_TAG);
        else if (b == TAG_NULL) phase = P_NULL;
        else if (b == TAG_INTEGER || b == TAG_OID || carries_bytes(b)) phase = P_LEN;
        else raise_err(ERR_UNSUPP);
      end
      P_LEN: begin
        if (b[7]) begin
          k            = b[6:0];
          content_left = '0;
          if (k > MAX_LEN_BYTES) begin
            raise_err(ERR_LEN_LONG);
          end else if (k == 0) begin
            length_known();
          end else begin
            len_left = k[2:0];
            phase    = P_LONG;
          end
        end else begin
          content_left = {24'd0, b};
          length_known();
        end
      end
      P_LONG: begin
        content_left = {content_left[23:0], b};
        len_left     = len_left - 3'd1;
        if (len_left == 0) length_known();
      end
      P_BODY: body_byte(b);
      default: begin
        // The byte after a NULL tag is taken and ignored.
        elem_done = 1'b1;
        put_res(KIND_NULL, 32'd0, ERR_NONE, 1'b1);
      end
    endcase
    if (!elem_done && it.final_byte) raise_err(ERR_TRUNCATED);
    if (elem_done) phase = P_TAG;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase         = P_TAG;
      tag_q         = '0;
      cap_q         = '0;
      len_left      = '0;
      content_left  = '0;
      acc           = '0;
      arcs_done     = '0;
      first_pending = 1'b1;
      results_due.delete();
      bad_n         = 0;
      seen_n        = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_item);
        foreach (step_out[i]) results_due.push_back(step_out[i]);
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          bad_n++;
          $display("%0t: unexpected result: expected none, got kind %0d value %h error %0d",
                   $time, out_item.kind, out_item.value, out_item.error_code,
                   " tag %h last %b", out_item.element_tag, out_item.last);
        end else begin
          due_item = results_due.pop_front();
          seen_n++;
          if (due_item.kind !== out_item.kind || due_item.value !== out_item.value ||
              due_item.error_code !== out_item.error_code ||
              due_item.element_tag !== out_item.element_tag ||
              due_item.last !== out_item.last) begin
            bad_n++;
            $display("%0t: mismatch: expected kind %0d value %h error %0d tag %h last %b",
                     $time, due_item.kind, due_item.value, due_item.error_code,
                     due_item.element_tag, due_item.last,
                     ", got kind %0d value %h error %0d tag %h last %b",
                     out_item.kind, out_item.value, out_item.error_code,
                     out_item.element_tag, out_item.last);
          end
        end
      end
    end
    mismatches <= bad_n;
    pending    <= results_due.size();
    checked    <= seen_n;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the BER element decoder testbench: clock, reset, byte stimulus and
// output back-pressure. Needs berdec_pkg, the decoder core and the checker.
module testbench;
  import berdec_pkg::*;

  localparam int ITEMS        = 1900;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int mismatches;
  int pending;
  int checked;

  int         bytes_sent;
  int         elements;
  int         hold_asks;
  int         holds_served;
  int         quiet;
  int         tx_odds;
  int         rx_odds;
  bit         calm;
  bit         asked_hold;
  bit         paused_once;
  logic [7:0] elem_bytes[$];

  ber_element_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  ber_element_decoder_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < tx_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Only the tag byte carries a meaningful expected tag and capacity.
  task automatic send_element(input logic [7:0] want_tag, input logic [7:0] cap,
                              input bit fin_last);
    in_item_t it;
    foreach (elem_bytes[i]) begin
      it.data_byte    = elem_bytes[i];
      it.expected_tag = (i == 0) ? want_tag : 8'($urandom);
      it.capacity     = (i == 0) ? cap : 8'($urandom);
      it.final_byte   = (i == elem_bytes.size() - 1) ? fin_last : 1'b0;
      send_byte(it);
    end
    elements++;
  endtask

  task automatic random_element();
    logic [7:0]  tag;
    logic [7:0]  want;
    logic [7:0]  cap;
    logic [7:0]  b;
    logic [31:0] lval;
    int          len;
    int          nbytes;
    int          subids;
    int          cut;
    bit          fin;
    bit          supported;
    bit          stops;
    bit          go_on;
    elem_bytes.delete();
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 2))
        0:       tx_odds = 0;
        1:       tx_odds = 8;
        default: tx_odds = 30;
      endcase
    end
    supported = 1'b1;
    case ($urandom_range(0, 8))
      0: tag = TAG_INTEGER;
      1: tag = TAG_BITSTR;
      2: tag = TAG_OCTETS;
      3: tag = TAG_NULL;
      4: tag = TAG_OID;
      5: tag = TAG_IPADDR;
      6: tag = TAG_OPAQUE;
      7: tag = TAG_NSAP;
      default: begin
        // Every supported tag is below 0x80, so this one is always rejected.
        tag       = 8'($urandom) | 8'h80;
        supported = 1'b0;
      end
    endcase
    want = ($urandom_range(0, 15) == 0) ? 8'($urandom) : tag;
    fin  = ($urandom_range(0, 7) == 0);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
    cap  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(len + $urandom_range(0, 20));
    elem_bytes.push_back(tag);
    if (want == tag && supported) begin
      if (tag == TAG_NULL) begin
        elem_bytes.push_back(8'($urandom));
      end else begin
        lval  = 32'(len);
        stops = 1'b0;
        case ($urandom_range(0, 11))
          0: begin
            lval = '0;
            elem_bytes.push_back(8'h80);
          end
          1: begin
            elem_bytes.push_back(8'(8'h80 | $urandom_range(5, 127)));
            stops = 1'b1;
          end
          2, 3, 4: begin
            nbytes = $urandom_range(1, 4);
            if (tag != TAG_OID && $urandom_range(0, 2) == 0) lval = $urandom | 32'h100;
            if (nbytes < 4) lval = lval & ((32'd1 << (8 * nbytes)) - 32'd1);
            elem_bytes.push_back(8'(8'h80 | nbytes));
            for (int i = nbytes - 1; i >= 0; i--) elem_bytes.push_back(8'(lval >> (8 * i)));
          end
          default: elem_bytes.push_back(8'(lval));
        endcase
        // Content is left out where the length already ends the element.
        if (!stops && (tag == TAG_OID || lval <= {24'd0, cap})) begin
          subids = 0;
          go_on  = 1'b1;
          for (int i = 0; i < lval && go_on; i++) begin
            if (tag == TAG_OID) begin
              b = {($urandom_range(0, 2) == 0), 7'($urandom)};
              elem_bytes.push_back(b);
              if (!b[7] || i == lval - 1) begin
                subids++;
                // The arc that overflows the capacity ends the element.
                if (subids + 1 > int'(cap)) go_on = 1'b0;
              end
            end else begin
              elem_bytes.push_back(8'($urandom));
            end
          end
        end
      end
    end
    if (elem_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, elem_bytes.size() - 1);
      while (elem_bytes.size() > cut) void'(elem_bytes.pop_back());
      fin = 1'b1;
    end
    send_element(want, cap, fin);
  endtask

  // Output back-pressure: random stall bursts, plus the long hold-off on request.
  initial begin
    rx_odds      = 10;
    holds_served = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < rx_odds) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
        if ($urandom_range(0, 199) == 0) begin
          case ($urandom_range(0, 2))
            0:       rx_odds = 0;
            1:       rx_odds = 8;
            default: rx_odds = 30;
          endcase
        end
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    in_item_t noise;
    int       n;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    tx_odds  = 8;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    elem_bytes = '{TAG_INTEGER};
    send_element(TAG_OID, 8'd0, 1'b0);
    elem_bytes = '{8'hFF};
    send_element(8'hFF, 8'd255, 1'b0);
    elem_bytes = '{TAG_NULL, 8'hFF};
    send_element(TAG_NULL, 8'd0, 1'b0);
    elem_bytes = '{TAG_INTEGER, 8'h00};
    send_element(TAG_INTEGER, 8'd0, 1'b0);
    elem_bytes = '{TAG_INTEGER, 8'h01, 8'h80};
    send_element(TAG_INTEGER, 8'd255, 1'b0);
    elem_bytes = '{TAG_OID, 8'h80};
    send_element(TAG_OID, 8'd2, 1'b0);
    elem_bytes = '{TAG_OID, 8'h02, 8'h2B, 8'h81};
    send_element(TAG_OID, 8'd255, 1'b0);
    elem_bytes = '{TAG_OID, 8'h01, 8'h7F};
    send_element(TAG_OID, 8'd3, 1'b0);
    elem_bytes = '{TAG_OID, 8'h00};
    send_element(TAG_OID, 8'd1, 1'b0);
    elem_bytes = '{TAG_OCTETS, 8'h00};
    send_element(TAG_OCTETS, 8'd0, 1'b0);
    elem_bytes = '{TAG_BITSTR, 8'h85};
    send_element(TAG_BITSTR, 8'd255, 1'b0);
    elem_bytes = '{TAG_IPADDR, 8'h04};
    send_element(TAG_IPADDR, 8'd3, 1'b0);
    elem_bytes = '{TAG_OPAQUE, 8'h02};
    send_element(TAG_OPAQUE, 8'd255, 1'b1);

    while (bytes_sent < ITEMS) begin
      if (!asked_hold && bytes_sent >= 600) begin
        asked_hold = 1'b1;
        hold_asks++;
      end
      if (!paused_once && bytes_sent >= 1200) begin
        paused_once = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (bytes_sent >= 1700) calm = 1'b1;
      if ($urandom_range(0, 24) == 0) begin
        // A burst of arbitrary bytes; the final byte flag on the last one
        // brings the parser back to expecting a tag.
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          noise.data_byte    = 8'($urandom);
          noise.expected_tag = 8'($urandom);
          noise.capacity     = 8'($urandom);
          noise.final_byte   = (i == n - 1) ? 1'b1 : 1'($urandom);
          send_byte(noise);
        end
      end else begin
        random_element();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench summary: %0d bytes in %0d elements, %0d results checked,",
             bytes_sent, elements, checked, " with one long output hold-off and one drain");
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[ber_element_decoder_core.f]
src/berdec_pkg.sv
src/berdec_front.sv
src/berdec_fifo.sv
src/berdec_back.sv
src/ber_element_decoder_core.sv
tb/ber_element_decoder_checker.sv
tb/testbench.sv
